// ===== hw/rtl/stt_pkg.sv =====
// Package for the sorted tag table: sizes, codes and the structs that
// travel between the command front end and the execution back end.
// No dependencies.
`timescale 1ns / 1ps
package stt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int CHILD_DEPTH = 8;
  localparam int TAG_AW      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
  localparam int CCNT_W      = $clog2(CHILD_DEPTH + 1);
  localparam int CMEM_AW     = TAG_AW + CHILD_AW;
  localparam int QDEPTH      = 2;

  localparam logic [1:0] OP_INS_TAG   = 2'd0;
  localparam logic [1:0] OP_INS_CHILD = 2'd1;
  localparam logic [1:0] OP_RD_TAG    = 2'd2;
  localparam logic [1:0] OP_RD_CHILD  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_BADIDX  = 3'd4;

  typedef struct packed {
    logic [1:0]         opcode;
    logic               is_search;
    logic signed [31:0] source_id;
    logic [31:0]        tag_type;
    logic [31:0]        chunk_number;
    logic               cache_children;
    logic [31:0]        child_id;
    logic [31:0]        child_type;
    logic [5:0]         entry_index;
    logic [2:0]         child_index;
  } cmd_t;

  // One table row. The slot points at the child row that this tag owns.
  typedef struct packed {
    logic signed [31:0] sid;
    logic [31:0]        typ;
    logic [31:0]        num;
    logic               flag;
    logic [CCNT_W-1:0]  cnt;
    logic [TAG_AW-1:0]  slot;
  } entry_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               found;
    logic [6:0]         position;
    logic [6:0]         entry_count;
    logic signed [31:0] source_id;
    logic [31:0]        tag_type;
    logic [31:0]        chunk_number;
    logic               cache_flag;
    logic [3:0]         child_count;
    logic [31:0]        child_id;
    logic [31:0]        child_type;
  } res_t;

endpackage

// ===== hw/rtl/stt_front.sv =====
// Command front end: takes transactions, tags them by kind and holds them
// in a short queue for the back end. Depends on stt_pkg.
`timescale 1ns / 1ps
module stt_front import stt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  localparam int QAW = $clog2(QDEPTH);

  cmd_t             q_mem [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]     n_r, n_nxt;
  logic             do_push, do_pop;
  cmd_t             push_tagged;

  assign full    = (n_r == (QAW + 1)'(QDEPTH));
  assign q_valid = (n_r != '0);
  assign q_cmd   = q_mem[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    push_tagged           = push_cmd;
    push_tagged.is_search = push_cmd.opcode inside {OP_INS_TAG, OP_INS_CHILD};
  end

  always_comb begin
    wp_nxt = do_push ? ((wp_r == QAW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt = do_pop  ? ((rp_r == QAW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1) : rp_r;
    n_nxt  = n_r + (QAW + 1)'(do_push) - (QAW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      n_r  <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      n_r  <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wp_r] <= push_tagged;
    end
  end

endmodule

// ===== hw/rtl/stt_back.sv =====
// Execution back end: binary search, row shifting and child insertion over
// the tag memory and the child memory. Depends on stt_pkg.
`timescale 1ns / 1ps
module stt_back import stt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic pop,
  output logic res_valid,
  output res_t res
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_SRCH   = 12'b000000000010,
    S_CMP    = 12'b000000000100,
    S_TSH_RD = 12'b000000001000,
    S_TSH_WR = 12'b000000010000,
    S_TWRITE = 12'b000000100000,
    S_CSH_RD = 12'b000001000000,
    S_CSH_WR = 12'b000010000000,
    S_CFIN   = 12'b000100000000,
    S_RD_TAG = 12'b001000000000,
    S_RD_USE = 12'b010000000000,
    S_RD_CH  = 12'b100000000000
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, pos_r, pos_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CCNT_W-1:0] cj_r, cj_nxt;
  entry_t           ent_r, ent_nxt;
  res_t             res_r, res_nxt;
  logic             vld_r, vld_nxt;
  logic [CNT_W:0]   mid_sum;

  entry_t              kmem [TABLE_DEPTH];
  entry_t              kq, kwd;
  logic [TAG_AW-1:0]   kra, kwa;
  logic                kwe;
  logic [63:0]         cmem [TABLE_DEPTH * CHILD_DEPTH];
  logic [63:0]         cq, cwd;
  logic [CMEM_AW-1:0]  cra, cwa;
  logic                cwe;
  logic                k_less, k_eq, c_gt;

  always_ff @(posedge clk) begin
    if (kwe) kmem[kwa] <= kwd;
    kq <= kmem[kra];
  end

  always_ff @(posedge clk) begin
    if (cwe) cmem[cwa] <= cwd;
    cq <= cmem[cra];
  end

  assign k_eq   = (cmd_r.source_id == kq.sid) && (cmd_r.tag_type == kq.typ) &&
                  (cmd_r.chunk_number == kq.num);
  assign k_less = (cmd_r.source_id < kq.sid) ||
                  ((cmd_r.source_id == kq.sid) && (cmd_r.tag_type < kq.typ)) ||
                  ((cmd_r.source_id == kq.sid) && (cmd_r.tag_type == kq.typ) &&
                   (cmd_r.chunk_number < kq.num));
  assign c_gt   = (cq[63:32] > cmd_r.child_type) ||
                  ((cq[63:32] == cmd_r.child_type) && (cq[31:0] > cmd_r.child_id));
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};

  assign pop       = (state_r == S_IDLE) && q_valid;
  assign res_valid = vld_r;
  assign res       = res_r;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    pos_nxt   = pos_r;
    j_nxt     = j_r;
    cj_nxt    = cj_r;
    ent_nxt   = ent_r;
    res_nxt   = res_r;
    vld_nxt   = 1'b0;
    kra = '0;
    kwe = 1'b0;
    kwa = '0;
    kwd = kq;
    cra = '0;
    cwe = 1'b0;
    cwa = '0;
    cwd = {cmd_r.child_type, cmd_r.child_id};
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cmd_nxt = q_cmd;
          res_nxt = '0;
          lo_nxt  = '0;
          hi_nxt  = count_r;
          state_nxt = q_cmd.is_search ? S_SRCH : S_RD_TAG;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_sum[CNT_W:1];
          kra       = mid_sum[TAG_AW:1];
          state_nxt = S_CMP;
        end else begin
          pos_nxt = lo_r;
          res_nxt.position    = 7'(lo_r);
          res_nxt.entry_count = 7'(count_r);
          if (cmd_r.opcode == OP_INS_CHILD) begin
            res_nxt.status = ST_MISSING;
            vld_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else if (count_r >= CNT_W'(TABLE_DEPTH)) begin
            res_nxt.status = ST_FULL;
            vld_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            j_nxt = count_r;
            state_nxt = S_TSH_RD;
          end
        end
      end
      S_CMP: begin
        if (k_eq) begin
          pos_nxt = mid_r;
          res_nxt.found       = 1'b1;
          res_nxt.position    = 7'(mid_r);
          res_nxt.entry_count = 7'(count_r);
          ent_nxt = kq;
          if (cmd_r.opcode == OP_INS_TAG) begin
            kwe = 1'b1;
            kwa = mid_r[TAG_AW-1:0];
            kwd = kq;
            kwd.flag = kq.flag | cmd_r.cache_children;
            res_nxt.status = ST_PRESENT;
            vld_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else if (kq.cnt >= CCNT_W'(CHILD_DEPTH)) begin
            res_nxt.status = ST_FULL;
            vld_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cj_nxt = kq.cnt;
            state_nxt = S_CSH_RD;
          end
        end else begin
          if (k_less) hi_nxt = mid_r;
          else        lo_nxt = mid_r + 1'b1;
          state_nxt = S_SRCH;
        end
      end
      // Rows above the insert point move up one, from the top down.
      S_TSH_RD: begin
        if (j_r == pos_r) begin
          state_nxt = S_TWRITE;
        end else begin
          kra = TAG_AW'(j_r - 1'b1);
          state_nxt = S_TSH_WR;
        end
      end
      S_TSH_WR: begin
        kwe = 1'b1;
        kwa = j_r[TAG_AW-1:0];
        kwd = kq;
        j_nxt = j_r - 1'b1;
        state_nxt = S_TSH_RD;
      end
      // Child rows are allocated in arrival order and never move.
      S_TWRITE: begin
        kwe = 1'b1;
        kwa = pos_r[TAG_AW-1:0];
        kwd.sid  = cmd_r.source_id;
        kwd.typ  = cmd_r.tag_type;
        kwd.num  = cmd_r.chunk_number;
        kwd.flag = cmd_r.cache_children;
        kwd.cnt  = '0;
        kwd.slot = count_r[TAG_AW-1:0];
        count_nxt = count_r + 1'b1;
        res_nxt.status      = ST_OK;
        res_nxt.entry_count = 7'(count_r + 1'b1);
        vld_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CSH_RD: begin
        if (cj_r == '0) begin
          cwe = 1'b1;
          cwa = {ent_r.slot, CHILD_AW'(0)};
          state_nxt = S_CFIN;
        end else begin
          cra = {ent_r.slot, CHILD_AW'(cj_r - 1'b1)};
          state_nxt = S_CSH_WR;
        end
      end
      S_CSH_WR: begin
        cwe = 1'b1;
        cwa = {ent_r.slot, cj_r[CHILD_AW-1:0]};
        if (c_gt) begin
          cwd = cq;
          cj_nxt = cj_r - 1'b1;
          state_nxt = S_CSH_RD;
        end else begin
          state_nxt = S_CFIN;
        end
      end
      S_CFIN: begin
        kwe = 1'b1;
        kwa = pos_r[TAG_AW-1:0];
        kwd = ent_r;
        kwd.cnt = ent_r.cnt + 1'b1;
        res_nxt.status = ST_OK;
        vld_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD_TAG: begin
        res_nxt.position    = 7'(cmd_r.entry_index);
        res_nxt.entry_count = 7'(count_r);
        if (CNT_W'(cmd_r.entry_index) >= count_r) begin
          res_nxt.status = ST_BADIDX;
          vld_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          kra = cmd_r.entry_index[TAG_AW-1:0];
          state_nxt = S_RD_USE;
        end
      end
      S_RD_USE: begin
        res_nxt.source_id    = kq.sid;
        res_nxt.tag_type     = kq.typ;
        res_nxt.chunk_number = kq.num;
        res_nxt.cache_flag   = kq.flag;
        res_nxt.child_count  = 4'(kq.cnt);
        if (cmd_r.opcode == OP_RD_TAG) begin
          res_nxt.status = ST_OK;
          vld_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (CCNT_W'(cmd_r.child_index) >= kq.cnt) begin
          res_nxt.status = ST_BADIDX;
          vld_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cra = {kq.slot, cmd_r.child_index[CHILD_AW-1:0]};
          state_nxt = S_RD_CH;
        end
      end
      S_RD_CH: begin
        res_nxt.child_id   = cq[31:0];
        res_nxt.child_type = cq[63:32];
        res_nxt.status = ST_OK;
        vld_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    pos_r <= pos_nxt;
    j_r   <= j_nxt;
    cj_r  <= cj_nxt;
    ent_r <= ent_nxt;
    res_r <= res_nxt;
  end

endmodule

// ===== hw/rtl/sorted_tag_table.sv =====
// Top level of the sorted tag table: command queue front end and execution
// back end. Depends on stt_pkg, stt_front and stt_back.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------
//   command  | start / busy        | in_opcode .. in_child_index
//   result   | out_valid (strobe)  | out_status .. out_read_child_type
//
// Each search probe (7 at most) is a read and a compare state; a tag insert
// then moves each row above the insert point, and a child insert each larger
// child, by a read and a write state per move. Reads pass through S_RD_TAG,
// S_RD_USE and, for a child read, S_RD_CH. A two-entry queue holds commands
// while one executes; busy rises when it is full. Reset is synchronous and
// empties the table; the memories need no clearing. Results cannot be stalled.
`timescale 1ns / 1ps
module sorted_tag_table import stt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_source_id,
  input  logic [31:0]        in_tag_type,
  input  logic [31:0]        in_chunk_number,
  input  logic               in_cache_children,
  input  logic [31:0]        in_child_id,
  input  logic [31:0]        in_child_type,
  input  logic [5:0]         in_entry_index,
  input  logic [2:0]         in_child_index,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic               out_found,
  output logic [6:0]         out_position,
  output logic [6:0]         out_entry_count,
  output logic signed [31:0] out_read_source_id,
  output logic [31:0]        out_read_tag_type,
  output logic [31:0]        out_read_chunk_number,
  output logic               out_read_cache_flag,
  output logic [3:0]         out_read_child_count,
  output logic [31:0]        out_read_child_id,
  output logic [31:0]        out_read_child_type
);

  cmd_t in_cmd, q_cmd;
  logic q_valid, pop;
  res_t res;

  always_comb begin
    in_cmd.opcode         = in_opcode;
    in_cmd.is_search      = 1'b0;
    in_cmd.source_id      = in_source_id;
    in_cmd.tag_type       = in_tag_type;
    in_cmd.chunk_number   = in_chunk_number;
    in_cmd.cache_children = in_cache_children;
    in_cmd.child_id       = in_child_id;
    in_cmd.child_type     = in_child_type;
    in_cmd.entry_index    = in_entry_index;
    in_cmd.child_index    = in_child_index;
  end

  stt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (start),
    .push_cmd (in_cmd),
    .full     (busy),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  stt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_status            = res.status;
  assign out_found             = res.found;
  assign out_position          = res.position;
  assign out_entry_count       = res.entry_count;
  assign out_read_source_id    = res.source_id;
  assign out_read_tag_type     = res.tag_type;
  assign out_read_chunk_number = res.chunk_number;
  assign out_read_cache_flag   = res.cache_flag;
  assign out_read_child_count  = res.child_count;
  assign out_read_child_id     = res.child_id;
  assign out_read_child_type   = res.child_type;

`ifndef ASSERT_OFF
  // Every result returns the back end to the idle state, which gives no result, so no two results are back to back.
  a_no_double_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("results on two consecutive cycles");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= 7'(TABLE_DEPTH)) else $error("tag count overflow");

  a_present_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_PRESENT) |-> out_found)
    else $error("present status without a match");

  a_missing_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_MISSING) |-> !out_found)
    else $error("missing status with a match");
`endif

endmodule
